[rtl/sglq_pkg.sv]
// ----------------------------------------------------------------------------
// sglq_pkg
// Shared types and constants for the signal gated lane queues block.
// ----------------------------------------------------------------------------
package sglq_pkg;

  localparam int LANES          = 3;
  localparam int DEF_LANE_DEPTH = 8;

  localparam int ID_W   = 16;
  localparam int TIME_W = 8;
  localparam int ELA_W  = 16;
  localparam int STAT_W = 3;
  localparam int PH_W   = 2;

  // Item modes.
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  // Lane code with no queue behind it.
  localparam logic [1:0] LANE_UNKNOWN = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_GREEN = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd4;

  // Signal phases.
  localparam logic [PH_W-1:0] PH_RED    = 2'd0;
  localparam logic [PH_W-1:0] PH_GREEN  = 2'd1;
  localparam logic [PH_W-1:0] PH_YELLOW = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RED    = 2'd0;
  localparam logic [1:0] CFG_GREEN  = 2'd1;
  localparam logic [1:0] CFG_YELLOW = 2'd2;

  // Reset values of the phase times.
  localparam logic [TIME_W-1:0] RED_RST    = 8'd10;
  localparam logic [TIME_W-1:0] GREEN_RST  = 8'd15;
  localparam logic [TIME_W-1:0] YELLOW_RST = 8'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

[rtl/signal_gated_lane_queues_top.sv]
// ----------------------------------------------------------------------------
// signal_gated_lane_queues_top
// Red, green, yellow signal that gates three vehicle ID queues.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_mode, in_lane, in_vehicle_id, in_elapsed) is taken at a
//   clock edge where start is high and busy is low. Add items queue an ID
//   in the truck, car or bike lane; remove items pop the lane head while
//   the signal is green; tick items run the phase timer down.
//   Exactly one result beat follows each item: out_valid is high for one
//   cycle, in the result state after the execute state, with status,
//   removed ID, phase and remaining time. The receiver cannot hold a
//   beat off. Each item passes through an execute state, where busy is
//   high, and a result state; start may be high during the result state,
//   so a new item can be taken while the last beat is on the ports. The
//   removed ID comes from a registered read of the lane memory.
//   Phase times are written on the cfg port (0 red, 1 green, 2 yellow)
//   while no item is in flight; a new time applies at the next phase load.
//   Reset (rst_n low, synchronous) restores red with 10 units left, the
//   default phase times and empty lanes. Queue contents are not cleared.
// ----------------------------------------------------------------------------
module signal_gated_lane_queues_top
  import sglq_pkg::*;
#(
  parameter int LANE_DEPTH = DEF_LANE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_lane,
  input  logic [ID_W-1:0]    in_vehicle_id,
  input  logic [ELA_W-1:0]   in_elapsed,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [ID_W-1:0]    out_removed_id,
  output logic [PH_W-1:0]    out_phase,
  output logic [TIME_W-1:0]  out_remaining,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [TIME_W-1:0]  cfg_wdata
);

  dp_cmd_t cmd;

  sglq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  sglq_dp #(
    .LANE_DEPTH (LANE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_lane        (in_lane),
    .in_vehicle_id  (in_vehicle_id),
    .in_elapsed     (in_elapsed),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_status     (out_status),
    .out_removed_id (out_removed_id),
    .out_phase      (out_phase),
    .out_remaining  (out_remaining)
  );

endmodule

[rtl/sglq_ctrl.sv]
// ----------------------------------------------------------------------------
// sglq_ctrl
// Sequencer: accepts an item, runs an execute state, presents the result.
// ----------------------------------------------------------------------------
module sglq_ctrl
  import sglq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // A new item may be taken while the result beat is on the ports.
        state_nxt = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = (state_r == S_EXEC);
    out_valid   = (state_r == S_RESP);
    cmd.exec    = (state_r == S_EXEC);
    cmd.capture = start && (state_r != S_EXEC);
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execute");

  a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |-> ($past(state_r) == S_EXEC))
    else $error("result beat without an execute cycle");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat held longer than one cycle");

endmodule

[rtl/sglq_dp.sv]
// ----------------------------------------------------------------------------
// sglq_dp
// Datapath: phase timer, lane pointers and counts, and the lane ID memory.
// ----------------------------------------------------------------------------
module sglq_dp
  import sglq_pkg::*;
#(
  parameter int LANE_DEPTH = DEF_LANE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_lane,
  input  logic [ID_W-1:0]    in_vehicle_id,
  input  logic [ELA_W-1:0]   in_elapsed,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [TIME_W-1:0]  cfg_wdata,
  output logic [STAT_W-1:0]  out_status,
  output logic [ID_W-1:0]    out_removed_id,
  output logic [PH_W-1:0]    out_phase,
  output logic [TIME_W-1:0]  out_remaining
);

  localparam int PW    = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
  localparam int CW    = $clog2(LANE_DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int TOTAL = LANES * LANE_DEPTH;
  localparam int AW    = $clog2(TOTAL);

  // Captured item.
  logic [1:0]        mode_r;
  logic [1:0]        lane_r;
  logic [ID_W-1:0]   id_r;
  logic [ELA_W-1:0]  elapsed_r;

  // Phase times and signal state.
  logic [TIME_W-1:0] red_r;
  logic [TIME_W-1:0] green_r;
  logic [TIME_W-1:0] yellow_r;
  logic [PH_W-1:0]   phase_r;
  logic [PH_W-1:0]   phase_nxt;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] time_nxt;

  // Lane queues.
  logic [PW-1:0]     head_r [LANES];
  logic [CW-1:0]     cnt_r  [LANES];
  logic [ID_W-1:0]   mem    [TOTAL];
  logic [ID_W-1:0]   rd_r;

  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;
  logic              rm_ok_r;
  logic              add_ok;
  logic              rm_ok;

  logic              lane_ok;
  logic [1:0]        li;
  logic [PW-1:0]     head_sel;
  logic [CW-1:0]     cnt_sel;
  logic [SW-1:0]     tail_sum;
  logic [PW-1:0]     tail_slot;
  logic [PW:0]       head_sum;
  logic [PW-1:0]     head_inc;
  logic [AW-1:0]     base;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [CW+1:0]     tot_cnt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= in_mode;
      lane_r    <= in_lane;
      id_r      <= in_vehicle_id;
      elapsed_r <= in_elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r    <= RED_RST;
      green_r  <= GREEN_RST;
      yellow_r <= YELLOW_RST;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_RED:    red_r    <= cfg_wdata;
        CFG_GREEN:  green_r  <= cfg_wdata;
        CFG_YELLOW: yellow_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    lane_ok  = (lane_r != LANE_UNKNOWN);
    li       = lane_ok ? lane_r : 2'd0;
    head_sel = head_r[li];
    cnt_sel  = cnt_r[li];

    // Tail slot wraps around the lane; head plus count stays below twice the depth.
    tail_sum  = SW'(head_sel) + SW'(cnt_sel);
    tail_slot = (tail_sum >= SW'(LANE_DEPTH)) ? PW'(tail_sum - SW'(LANE_DEPTH))
                                              : PW'(tail_sum);
    head_sum  = (PW+1)'(head_sel) + (PW+1)'(1);
    head_inc  = (head_sum == (PW+1)'(LANE_DEPTH)) ? '0 : PW'(head_sum);

    base  = AW'(li) * AW'(LANE_DEPTH);
    waddr = base + AW'(tail_slot);
    raddr = base + AW'(head_sel);
  end

  always_comb begin
    status_nxt = ST_OK;
    add_ok     = 1'b0;
    rm_ok      = 1'b0;
    phase_nxt  = phase_r;
    time_nxt   = time_r;
    unique case (mode_r)
      MODE_ADD: begin
        if (!lane_ok) begin
          status_nxt = ST_UNKNOWN;
        end else if (cnt_sel == CW'(LANE_DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          add_ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (!lane_ok) begin
          status_nxt = ST_UNKNOWN;
        end else if (phase_r != PH_GREEN) begin
          status_nxt = ST_NOT_GREEN;
        end else if (cnt_sel == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          rm_ok = 1'b1;
        end
      end
      MODE_TICK: begin
        if (elapsed_r >= ELA_W'(time_r)) begin
          // Overshoot is dropped; the next phase starts with its full time.
          unique case (phase_r)
            PH_RED: begin
              phase_nxt = PH_GREEN;
              time_nxt  = green_r;
            end
            PH_GREEN: begin
              phase_nxt = PH_YELLOW;
              time_nxt  = yellow_r;
            end
            default: begin
              phase_nxt = PH_RED;
              time_nxt  = red_r;
            end
          endcase
        end else begin
          time_nxt = time_r - TIME_W'(elapsed_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RED;
      time_r  <= RED_RST;
      for (int i = 0; i < LANES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (cmd.exec) begin
      phase_r <= phase_nxt;
      time_r  <= time_nxt;
      for (int i = 0; i < LANES; i++) begin
        if (li == 2'(i)) begin
          if (add_ok) begin
            cnt_r[i] <= cnt_r[i] + CW'(1);
          end else if (rm_ok) begin
            cnt_r[i]  <= cnt_r[i] - CW'(1);
            head_r[i] <= head_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      rm_ok_r  <= rm_ok;
      rd_r     <= mem[raddr];
      if (add_ok) begin
        mem[waddr] <= id_r;
      end
    end
  end

  assign out_status     = status_r;
  assign out_removed_id = rm_ok_r ? rd_r : '0;
  assign out_phase      = phase_r;
  assign out_remaining  = time_r;

  assign tot_cnt = (CW+2)'(cnt_r[0]) + (CW+2)'(cnt_r[1]) + (CW+2)'(cnt_r[2]);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CW'(LANE_DEPTH)) && (cnt_r[1] <= CW'(LANE_DEPTH))
      && (cnt_r[2] <= CW'(LANE_DEPTH)))
    else $error("lane count exceeds lane depth");

  a_gate_red: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && mode_r == MODE_REMOVE && lane_ok && phase_r != PH_GREEN)
      |=> (status_r == ST_NOT_GREEN) && !rm_ok_r)
    else $error("remove not blocked outside green");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && add_ok) |=> (tot_cnt == $past(tot_cnt) + (CW+2)'(1)))
    else $error("successful add did not grow the queued total");

endmodule
